// File: rtl/core/tpm_pkg.sv
// ----------------------------------------------------------------------------
// tpm_pkg: shared types and constants of the temporal property monitor
// Holds the property kinds, operation codes, register map and the per-lane
// flag bundle that travels from the lanes to the merging stage.
// ----------------------------------------------------------------------------
package tpm_pkg;

  // Default number of predicate lanes.
  localparam int unsigned MaxPredicates = 16;

  // Predicates that the item fields can address (p/q bits, kinds, witness index).
  localparam int unsigned FieldLanes = 16;

  localparam int unsigned SampleW   = 64;
  localparam int unsigned CondW     = 16;
  localparam int unsigned IdxW      = 4;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned CountW    = 5;
  localparam int unsigned KindTabW  = 32;

  // Stream payload widths (packed fields padded to whole bytes).
  localparam int unsigned InDataW   = 104;
  localparam int unsigned OutDataW  = 72;

  // Configuration port.
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam logic [ApbAddrW-1:0] RegActiveCount = 3'h0;
  localparam logic [ApbAddrW-1:0] RegKindTable   = 3'h4;

  // Status with all three property classes satisfied.
  localparam logic [StatusW-1:0] StatusAll = 3'h7;

  // Operation carried in tuser.
  localparam logic FuncObserve = 1'b0;
  localparam logic FuncRead    = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALWAYS     = 2'd0,
    KIND_EVENTUALLY = 2'd1,
    KIND_RESPONDS   = 2'd2,
    KIND_UNKNOWN    = 2'd3
  } kind_e;

  typedef struct packed {
    logic violated;
    logic fired;
    logic pending;
    logic resolved;
  } flags_t;

endpackage

// File: rtl/core/tpm_lane.sv
// ----------------------------------------------------------------------------
// tpm_lane: one predicate checker
// Keeps the four status flags and the witness word of a single predicate and
// updates them on every observed sample while the lane is active.
// ----------------------------------------------------------------------------
module tpm_lane (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          obs_en_i,
  input  tpm_pkg::kind_e                kind_i,
  input  logic                          p_i,
  input  logic                          q_i,
  input  logic [tpm_pkg::SampleW-1:0]   sample_i,
  output tpm_pkg::flags_t               flags_d_o,
  output logic [tpm_pkg::SampleW-1:0]   witness_o
);

  tpm_pkg::flags_t                 flags_q, flags_d;
  logic [tpm_pkg::SampleW-1:0]     witness_q, witness_d;
  logic                            pend_set;

  always_comb begin
    flags_d   = flags_q;
    witness_d = witness_q;
    pend_set  = flags_q.pending | p_i;
    if (obs_en_i) begin
      unique case (kind_i)
        tpm_pkg::KIND_ALWAYS: begin
          if (!p_i && !flags_q.violated) begin
            flags_d.violated = 1'b1;
            witness_d        = sample_i;
          end
        end
        tpm_pkg::KIND_EVENTUALLY: begin
          if (p_i) begin
            flags_d.fired = 1'b1;
          end
        end
        tpm_pkg::KIND_RESPONDS: begin
          // A trigger and its response may arrive in the same sample.
          if (pend_set && q_i) begin
            flags_d.resolved = 1'b1;
            flags_d.pending  = 1'b0;
          end else begin
            flags_d.pending  = pend_set;
          end
        end
        default: begin
          flags_d.violated = 1'b1;
          witness_d        = sample_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q   <= '0;
      witness_q <= '0;
    end else begin
      flags_q   <= flags_d;
      witness_q <= witness_d;
    end
  end

  assign flags_d_o = flags_d;
  assign witness_o = witness_q;

endmodule

// File: rtl/core/tpm_merge.sv
// ----------------------------------------------------------------------------
// tpm_merge: status reduction and witness selection
// Combines the post-update flags of all active lanes into the three status
// bits and selects the witness word for a read.
// ----------------------------------------------------------------------------
module tpm_merge #(
  parameter int unsigned NumLanes = tpm_pkg::MaxPredicates
) (
  input  tpm_pkg::flags_t               lane_flags_i [NumLanes],
  input  tpm_pkg::kind_e                lane_kind_i  [NumLanes],
  input  logic [NumLanes-1:0]           lane_active_i,
  input  logic [tpm_pkg::SampleW-1:0]   witness_i    [tpm_pkg::FieldLanes],
  input  logic                          rd_en_i,
  input  logic [tpm_pkg::IdxW-1:0]      rd_idx_i,
  input  logic [tpm_pkg::CountW-1:0]    count_i,
  output logic [tpm_pkg::StatusW-1:0]   status_o,
  output logic                          all_ok_o,
  output logic [tpm_pkg::SampleW-1:0]   witness_o
);

  logic [NumLanes-1:0] a_bad, e_bad, r_bad;

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      a_bad[i] = lane_active_i[i] && (lane_kind_i[i] == tpm_pkg::KIND_ALWAYS)
                 && lane_flags_i[i].violated;
      e_bad[i] = lane_active_i[i] && (lane_kind_i[i] == tpm_pkg::KIND_EVENTUALLY)
                 && !lane_flags_i[i].fired;
      r_bad[i] = lane_active_i[i] && (lane_kind_i[i] == tpm_pkg::KIND_RESPONDS)
                 && (!lane_flags_i[i].resolved || lane_flags_i[i].pending);
    end
  end

  assign status_o = {~|r_bad, ~|e_bad, ~|a_bad};
  assign all_ok_o = (status_o == tpm_pkg::StatusAll);

  assign witness_o = (rd_en_i && ({1'b0, rd_idx_i} < count_i)) ? witness_i[rd_idx_i]
                                                                : '0;

endmodule

// File: rtl/core/temporal_property_monitor.sv
// ----------------------------------------------------------------------------
// temporal_property_monitor: runtime checker for trace properties
// Checks every sample of a trace against up to MaxPredicates properties of
// kind always, eventually or responds, and reads back stored witnesses.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Contents
//   s_axis    in         tuser: func; tdata: sample_value, p_bits, q_bits,
//                        pred_index
//   m_axis    out        tdata: status_bits, all_ok, witness_word
//   apb       in/out     reg 0 active_count at 0x0, reg 1 kind_table at 0x4
//
// All predicate lanes update in parallel at the accepting edge and the merged
// status is captured in the output register at that same edge, so one item can
// be accepted every cycle while the result stream keeps draining the output.
// The output register is the only stage; a new transfer is accepted whenever
// it is empty or is being drained in the same cycle.
// Reset clears all flags, all witnesses, both registers and the output
// register; the monitor is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module temporal_property_monitor #(
  parameter int unsigned MaxPredicates = tpm_pkg::MaxPredicates
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Input stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [63:0] sample_value, [79:64] p_bits, [95:80] q_bits, [99:96] pred_index
  input  logic [tpm_pkg::InDataW-1:0]     s_axis_tdata,
  // [0] func
  input  logic [0:0]                      s_axis_tuser,

  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [2:0] status_bits, [3] all_ok, [67:4] witness_word
  output logic [tpm_pkg::OutDataW-1:0]    m_axis_tdata,

  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpm_pkg::ApbAddrW-1:0]    paddr,
  input  logic [tpm_pkg::ApbDataW-1:0]    pwdata,
  output logic [tpm_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int unsigned CW = tpm_pkg::CountW;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [CW-1:0]                active_count_q;
  logic [tpm_pkg::KindTabW-1:0] kind_table_q;
  logic                         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      kind_table_q   <= '0;
    end else if (cfg_wr) begin
      unique case (paddr)
        tpm_pkg::RegActiveCount: active_count_q <= pwdata[CW-1:0];
        tpm_pkg::RegKindTable:   kind_table_q   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      tpm_pkg::RegActiveCount: prdata = {{(tpm_pkg::ApbDataW-CW){1'b0}}, active_count_q};
      tpm_pkg::RegKindTable:   prdata = kind_table_q;
      default:                 prdata = '0;
    endcase
  end

  // A count above the lane count behaves as the lane count.
  logic [CW-1:0] live_count;
  assign live_count = (32'(active_count_q) > MaxPredicates) ? CW'(MaxPredicates)
                                                            : active_count_q;

  // --------------------------------------------------------------------------
  // Input unpacking and handshake
  // --------------------------------------------------------------------------
  logic                              in_func;
  logic [tpm_pkg::SampleW-1:0]       in_sample;
  logic [tpm_pkg::CondW-1:0]         in_p, in_q;
  logic [tpm_pkg::IdxW-1:0]          in_idx;
  logic                              out_valid_q;
  logic                              in_xfer;
  logic                              obs_xfer;

  assign in_func   = s_axis_tuser[0];
  assign in_sample = s_axis_tdata[63:0];
  assign in_p      = s_axis_tdata[79:64];
  assign in_q      = s_axis_tdata[95:80];
  assign in_idx    = s_axis_tdata[99:96];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign obs_xfer      = in_xfer && (in_func == tpm_pkg::FuncObserve);

  // --------------------------------------------------------------------------
  // Predicate lanes. Lanes past the item fields see kind always with p and q
  // low, so when active they violate on their first sample.
  // --------------------------------------------------------------------------
  tpm_pkg::flags_t             lane_flags [MaxPredicates];
  tpm_pkg::kind_e              lane_kind  [MaxPredicates];
  logic [MaxPredicates-1:0]    lane_active;
  logic [tpm_pkg::SampleW-1:0] lane_wit   [MaxPredicates];
  logic [tpm_pkg::SampleW-1:0] field_wit  [tpm_pkg::FieldLanes];

  for (genvar i = 0; i < MaxPredicates; i++) begin : g_lane
    logic lane_p, lane_q;

    if (i < tpm_pkg::FieldLanes) begin : g_field
      assign lane_kind[i] = tpm_pkg::kind_e'(kind_table_q[2*i +: 2]);
      assign lane_p       = in_p[i];
      assign lane_q       = in_q[i];
    end else begin : g_extra
      assign lane_kind[i] = tpm_pkg::KIND_ALWAYS;
      assign lane_p       = 1'b0;
      assign lane_q       = 1'b0;
    end

    assign lane_active[i] = (32'(i) < 32'(live_count));

    tpm_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .obs_en_i  (obs_xfer && lane_active[i]),
      .kind_i    (lane_kind[i]),
      .p_i       (lane_p),
      .q_i       (lane_q),
      .sample_i  (in_sample),
      .flags_d_o (lane_flags[i]),
      .witness_o (lane_wit[i])
    );
  end

  // Witnesses reachable through pred_index; missing lanes read as zero.
  for (genvar j = 0; j < tpm_pkg::FieldLanes; j++) begin : g_wit
    if (j < MaxPredicates) begin : g_have
      assign field_wit[j] = lane_wit[j];
    end else begin : g_none
      assign field_wit[j] = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Merging stage: status from the post-update flags, witness for a read.
  // --------------------------------------------------------------------------
  logic [tpm_pkg::StatusW-1:0] mrg_status;
  logic                        mrg_all_ok;
  logic [tpm_pkg::SampleW-1:0] mrg_witness;

  tpm_merge #(
    .NumLanes (MaxPredicates)
  ) u_merge (
    .lane_flags_i  (lane_flags),
    .lane_kind_i   (lane_kind),
    .lane_active_i (lane_active),
    .witness_i     (field_wit),
    .rd_en_i       (in_func == tpm_pkg::FuncRead),
    .rd_idx_i      (in_idx),
    .count_i       (live_count),
    .status_o      (mrg_status),
    .all_ok_o      (mrg_all_ok),
    .witness_o     (mrg_witness)
  );

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [tpm_pkg::OutDataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (in_xfer) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {4'b0000, mrg_witness, mrg_all_ok, mrg_status};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
